[hw/rtl/mkpd_pkg.sv]
// Shared types and constants for the matrix keypad press detector.
package mkpd_pkg;

    localparam int MAX_COLS     = 8;
    localparam int MAX_ROWS     = 8;
    localparam int KEYMAP_DEPTH = 64;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int KM_AW  = $clog2(KEYMAP_DEPTH);
    localparam int CODE_W = 16;
    localparam int CNT_W  = 4;

    // opcodes of an input transaction
    localparam logic OP_MAP_WRITE = 1'b0;
    localparam logic OP_SAMPLE    = 1'b1;

    // register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic [MAX_ROWS-1:0] ROW_MASK_ALL = 8'hff;

    typedef struct packed {
        logic [CODE_W-1:0]   map_code;
        logic [KM_AW-1:0]    map_index;
        logic [MAX_ROWS-1:0] row_raw;
        logic [COL_W-1:0]    column;
        logic                opcode;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]   map_code;
        logic [KM_AW-1:0]    map_index;
        logic [MAX_ROWS-1:0] press;
        logic [COL_W-1:0]    column;
        logic                opcode;
    } t_scan_item;

    // saturate a count register to a maximum
    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] lim);
        sat_cnt = (v > lim) ? lim : v;
    endfunction

    // row shift: ceil(log2(columns in use))
    function automatic logic [1:0] cols_to_shift(input logic [CNT_W-1:0] cols);
        logic [1:0] s;
        if (cols <= 4'd1) begin
            s = 2'd0;
        end else if (cols <= 4'd2) begin
            s = 2'd1;
        end else if (cols <= 4'd4) begin
            s = 2'd2;
        end else begin
            s = 2'd3;
        end
        cols_to_shift = s;
    endfunction

endpackage

[hw/rtl/mkpd_col_stage.sv]
// Column state memory with read-modify-write; turns a row sample into a new-press mask.
module mkpd_col_stage import mkpd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    input  logic [CNT_W-1:0] i_num_rows,
    input  logic [CNT_W-1:0] i_num_cols,
    output logic             o_valid,
    output t_scan_item       o_item,
    input  logic             i_take
);

    // column state memory and its valid bits (cleared by reset)
    logic [MAX_ROWS-1:0] r_cs_mem [MAX_COLS];
    logic [MAX_COLS-1:0] r_cs_vld;

    logic                r_s1_vld;
    t_in_item            r_s1_item;
    logic [MAX_ROWS-1:0] r_cs_old;

    logic                accept;
    logic [CNT_W-1:0]    eff_rows;
    logic [CNT_W-1:0]    eff_cols;
    logic                col_ok;
    logic [MAX_ROWS-1:0] row_mask;
    logic [MAX_ROWS-1:0] now_rows;
    logic                wr_en;

    assign o_ready = !r_s1_vld || i_take;
    assign accept  = i_valid && o_ready;

    // masks from the configured counts
    assign eff_rows = sat_cnt(i_num_rows, CNT_W'(MAX_ROWS));
    assign eff_cols = sat_cnt(i_num_cols, CNT_W'(MAX_COLS));
    assign col_ok   = {1'b0, r_s1_item.column} < eff_cols;
    assign row_mask = (eff_rows >= CNT_W'(MAX_ROWS)) ? ROW_MASK_ALL :
                      MAX_ROWS'((9'd1 << eff_rows) - 9'd1);
    assign now_rows = ~r_s1_item.row_raw & row_mask;

    // write back the new state when the sample moves on
    assign wr_en = r_s1_vld && i_take && (r_s1_item.opcode == OP_SAMPLE) && col_ok;

    always_comb begin
        o_valid          = r_s1_vld;
        o_item.opcode    = r_s1_item.opcode;
        o_item.column    = r_s1_item.column;
        o_item.map_index = r_s1_item.map_index;
        o_item.map_code  = r_s1_item.map_code;
        o_item.press     = ((r_s1_item.opcode == OP_SAMPLE) && col_ok) ?
                           (now_rows & ~r_cs_old) : '0;
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_cs_vld <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
            if (wr_en) begin
                r_cs_vld[r_s1_item.column] <= 1'b1;
            end
        end
    end

    // memory write and registered read, forwarding a same-column write-back
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cs_mem[r_s1_item.column] <= now_rows;
        end
        if (accept) begin
            r_s1_item <= i_item;
            if (wr_en && (r_s1_item.column == i_item.column)) begin
                r_cs_old <= now_rows;
            end else if (r_cs_vld[i_item.column]) begin
                r_cs_old <= r_cs_mem[i_item.column];
            end else begin
                r_cs_old <= '0;
            end
        end
    end

endmodule

[hw/rtl/mkpd_scan.sv]
// Keymap memory, per-row lookup sequencer, last-marker hold and output register.
module mkpd_scan import mkpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_take,
    input  t_scan_item        i_item,
    input  logic [CNT_W-1:0]  i_num_cols,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CODE_W-1:0] o_out_code,
    output logic              o_out_last
);

    // keymap memory and its valid bits (cleared by reset)
    logic [CODE_W-1:0]       r_km_mem [KEYMAP_DEPTH];
    logic [KEYMAP_DEPTH-1:0] r_km_vld;

    logic                r_sc_vld;
    t_scan_item          r_sc_item;
    logic [MAX_ROWS-1:0] r_rem;

    logic              r_d_vld;
    logic              r_d_final;
    logic [CODE_W-1:0] r_rd_data;
    logic              r_rd_mvld;

    logic              r_pend_vld;
    logic              r_pend_fin;
    logic [CODE_W-1:0] r_pend_code;
    logic              n_pend_vld;
    logic              n_pend_fin;
    logic [CODE_W-1:0] n_pend_code;

    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_last;

    logic                adv;
    logic                step;
    logic                is_wr;
    logic [MAX_ROWS-1:0] rem_next;
    logic                sc_done;
    logic                rd_en;
    logic [ROW_W-1:0]    low_row;
    logic [1:0]          shift;
    logic [KM_AW-1:0]    rd_addr;
    logic [CODE_W-1:0]   d_code;
    logic                d_hit;
    logic                fin_eff;
    logic                push;

    // the lookup steps and the output register move only when the output register can take a value
    assign adv      = !r_out_vld || i_out_ready;
    assign step     = r_sc_vld && adv;
    assign is_wr    = r_sc_item.opcode == OP_MAP_WRITE;
    assign rem_next = r_rem & (r_rem - MAX_ROWS'(1));
    assign sc_done  = step && (is_wr || (rem_next == '0));
    assign o_take   = !r_sc_vld || sc_done;
    assign rd_en    = step && !is_wr && (r_rem != '0);

    // lowest pending row
    always_comb begin
        low_row = '0;
        for (int i = MAX_ROWS - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                low_row = ROW_W'(i);
            end
        end
    end

    assign shift   = cols_to_shift(sat_cnt(i_num_cols, CNT_W'(MAX_COLS)));
    assign rd_addr = KM_AW'(({{(KM_AW-ROW_W){1'b0}}, low_row} << shift) +
                            {{(KM_AW-COL_W){1'b0}}, r_sc_item.column});

    // lookup result and last-marker hold
    assign d_code  = r_rd_mvld ? r_rd_data : '0;
    assign d_hit   = r_d_vld && (d_code != '0);
    assign fin_eff = r_pend_fin || (r_d_vld && r_d_final && !d_hit);
    assign push    = r_pend_vld && (d_hit || fin_eff);

    always_comb begin
        n_pend_vld  = r_pend_vld;
        n_pend_fin  = fin_eff;
        n_pend_code = r_pend_code;
        if (d_hit) begin
            n_pend_vld  = 1'b1;
            n_pend_fin  = r_d_final;
            n_pend_code = d_code;
        end else if (push) begin
            n_pend_vld = 1'b0;
            n_pend_fin = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_vld   <= 1'b0;
            r_d_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_pend_fin <= 1'b0;
            r_out_vld  <= 1'b0;
            r_km_vld   <= '0;
        end else begin
            if (o_take && i_valid) begin
                r_sc_vld <= 1'b1;
            end else if (sc_done) begin
                r_sc_vld <= 1'b0;
            end
            if (adv) begin
                r_d_vld    <= rd_en;
                r_pend_vld <= n_pend_vld;
                r_pend_fin <= n_pend_fin;
                r_out_vld  <= push;
            end
            if (step && is_wr) begin
                r_km_vld[r_sc_item.map_index] <= 1'b1;
            end
        end
    end

    // payload registers and keymap memory
    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_sc_item <= i_item;
            r_rem     <= i_item.press;
        end else if (step && !is_wr) begin
            r_rem <= rem_next;
        end
        if (step && is_wr) begin
            r_km_mem[r_sc_item.map_index] <= r_sc_item.map_code;
        end
        if (rd_en) begin
            r_rd_data <= r_km_mem[rd_addr];
            r_rd_mvld <= r_km_vld[rd_addr];
            r_d_final <= rem_next == '0;
        end
        if (adv) begin
            r_pend_code <= n_pend_code;
            if (push) begin
                r_out_code <= r_pend_code;
                r_out_last <= fin_eff;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_code  = r_out_code;
    assign o_out_last  = r_out_last;

endmodule

[hw/rtl/matrix_keypad_press_detector_core.sv]
// Matrix keypad press detector: top level with stream ports and register port.
//
// Each input transaction is a keymap write or one column's active-low row sample.
// A sample passes a column-state read-modify-write stage (a new item may
// follow every cycle while the sequencer takes items; a back-to-back sample of
// the same column gets the just-written state forwarded), then a lookup
// sequencer that reads the keymap once per newly pressed row, lowest row first.
// A keymap write or a sample without new presses takes one sequencer step; the
// sequencer stalls while a keycode waits at the output. Keycodes pass the keymap
// read register, a pending hold and the output register; tlast marks the last
// keycode of a sample, and a key whose keymap entry is zero yields nothing.
// Registers: 0x0 num_rows, 0x4 num_cols (4 bits each, reset 8, larger values
// act as 8). Write them only while the block is idle. Reset clears key state
// and keymap at once; no clearing pass is needed.
module matrix_keypad_press_detector_core import mkpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // column[2:0], row_raw[10:3], map_index[16:11],
                                   // map_code[32:17], zero[39:33]
    input  logic [0:0]  s_tuser,   // opcode[0]: 0 keymap write, 1 row sample
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // keycode[15:0]
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_num_rows;
    logic [CNT_W-1:0] r_num_cols;
    logic             cfg_wr;

    t_in_item   in_item;
    logic       col_valid;
    t_scan_item col_item;
    logic       scan_take;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CNT_W'(MAX_ROWS);
            r_num_cols <= CNT_W'(MAX_COLS);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_ROWS: r_num_rows <= pwdata[CNT_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[CNT_W-1:0];
                default:      r_num_rows <= r_num_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_ROWS: prdata = 32'(r_num_rows);
            REG_NUM_COLS: prdata = 32'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    // unpack the input transaction
    always_comb begin
        in_item.opcode    = s_tuser[0];
        in_item.column    = s_tdata[2:0];
        in_item.row_raw   = s_tdata[10:3];
        in_item.map_index = s_tdata[16:11];
        in_item.map_code  = s_tdata[32:17];
    end

    mkpd_col_stage u_col (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_item     (in_item),
        .i_num_rows (r_num_rows),
        .i_num_cols (r_num_cols),
        .o_valid    (col_valid),
        .o_item     (col_item),
        .i_take     (scan_take)
    );

    mkpd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (col_valid),
        .o_take      (scan_take),
        .i_item      (col_item),
        .i_num_cols  (r_num_cols),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_code  (m_tdata),
        .o_out_last  (m_tlast)
    );

endmodule

[test/tb_keypad_checker.sv]
// Scoreboard for the keypad press detector: tracks registers, predicts keycodes, checks output.
`timescale 1ns / 1ps
module tb_keypad_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // column[2:0], row_raw[10:3], map_index[16:11],
                                     // map_code[32:17], zero[39:33]
    input  logic [0:0]  i_s_tuser,   // opcode[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // keycode[15:0]
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    input  logic        i_end_check,
    output int          o_fail_cnt,
    output int          o_pending,
    output int          o_key_cnt
);
    import mkpd_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_key_event;

    t_key_event          expected_keys[$];
    t_key_event          want;
    t_in_item            in_item;
    logic [MAX_ROWS-1:0] col_state [MAX_COLS];
    logic [CODE_W-1:0]   key_map [KEYMAP_DEPTH];
    logic [CNT_W-1:0]    rows_reg = 4'd8;
    logic [CNT_W-1:0]    cols_reg = 4'd8;
    logic [CNT_W-1:0]    reg_val;
    int                  mismatches = 0;
    int                  keys_seen  = 0;
    bit                  end_done   = 1'b0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int unsigned in_use(input logic [CNT_W-1:0] v, input int unsigned lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    // expected keycodes of one row sample, lowest row first; updates the column state
    task automatic predict_sample(input logic [COL_W-1:0] col, input logic [MAX_ROWS-1:0] raw);
        int unsigned         rows;
        int unsigned         cols;
        int unsigned         shift;
        int unsigned         n_new;
        logic [MAX_ROWS-1:0] mask;
        logic [MAX_ROWS-1:0] now;
        logic [MAX_ROWS-1:0] fresh;
        logic [KM_AW-1:0]    key;
        cols = in_use(cols_reg, MAX_COLS);
        if (col < cols) begin
            rows  = in_use(rows_reg, MAX_ROWS);
            shift = 0;
            while ((1 << shift) < cols) shift++;
            mask  = MAX_ROWS'((1 << rows) - 1);
            now   = ~raw & mask;
            fresh = (now ^ col_state[col]) & now;
            n_new = 0;
            for (int r = 0; r < rows; r++) begin
                key = KM_AW'((r << shift) + col);
                if (fresh[r] && key_map[key] != '0) begin
                    expected_keys.push_back('{code: key_map[key], last: 1'b0});
                    n_new++;
                end
            end
            if (n_new > 0) expected_keys[expected_keys.size()-1].last = 1'b1;
            col_state[col] = now;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = 4'd8;
            cols_reg = 4'd8;
            expected_keys.delete();
            for (int c = 0; c < MAX_COLS; c++) col_state[c] = '0;
            for (int k = 0; k < KEYMAP_DEPTH; k++) key_map[k] = '0;
        end else begin
            // register port: track writes, check read data
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_NUM_COLS) cols_reg = i_pwdata[CNT_W-1:0];
                    else rows_reg = i_pwdata[CNT_W-1:0];
                end else begin
                    reg_val = (i_paddr[2] == REG_NUM_COLS) ? cols_reg : rows_reg;
                    if (i_prdata !== {28'd0, reg_val})
                        report_mismatch($sformatf("read of 0x%h gave %h, want %h",
                                                  i_paddr, i_prdata, reg_val));
                end
            end

            // output transaction against the oldest expected keycode
            if (i_m_tvalid && i_m_tready) begin
                keys_seen++;
                if (expected_keys.size() == 0) begin
                    report_mismatch($sformatf("keycode %h with no press pending", i_m_tdata));
                end else begin
                    want = expected_keys.pop_front();
                    if (i_m_tdata !== want.code)
                        report_mismatch($sformatf("keycode %h, want %h", i_m_tdata, want.code));
                    if (i_m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b on keycode %h, want %b",
                                                  i_m_tlast, i_m_tdata, want.last));
                end
            end

            // input transaction: keymap write or row sample
            if (i_s_tvalid && i_s_tready) begin
                in_item = t_in_item'({i_s_tdata[$bits(t_in_item)-2:0], i_s_tuser[0]});
                if (in_item.opcode == OP_MAP_WRITE)
                    key_map[in_item.map_index] = in_item.map_code;
                else
                    predict_sample(in_item.column, in_item.row_raw);
            end

            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (expected_keys.size() != 0)
                    report_mismatch($sformatf("%0d keycodes never arrived",
                                              expected_keys.size()));
            end
        end
        o_fail_cnt <= mismatches;
        o_pending  <= expected_keys.size();
        o_key_cnt  <= keys_seen;
    end

endmodule

[test/tb_top.sv]
// Testbench top for the keypad press detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import mkpd_pkg::*;

    localparam int PHASES      = 10;
    localparam int QUIET_LIMIT = 4000;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // column[2:0], row_raw[10:3], map_index[16:11],
                                  // map_code[32:17], zero[39:33]
    logic [0:0]  s_tuser  = '0;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // keycode[15:0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        calm      = 1'b0;
    logic        end_check = 1'b0;
    int          fail_cnt;
    int          pending;
    int          key_cnt;
    int          items_sent   = 0;
    int          samples_sent = 0;
    int          quiet_cycles = 0;
    int unsigned rows_cfg [PHASES] = '{8, 1, 8, 1, 15, 0, 6, 3, 5, 4};
    int unsigned cols_cfg [PHASES] = '{8, 1, 1, 8, 15, 5, 0, 3, 2, 7};

    matrix_keypad_press_detector_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_keypad_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tlast  (m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .i_end_check(end_check),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_key_cnt  (key_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls about 14% of cycles, never in the calm phase
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 14);
    end

    // watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("[matrix_keypad_press_detector_core] ERROR");
            $finish;
        end
    end

    task automatic push_item(input t_in_item item);
        if (!calm && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, item[$bits(t_in_item)-1:1]};
        s_tuser  <= item.opcode;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        if (item.opcode == OP_SAMPLE) samples_sent++;
    endtask

    task automatic map_write(input logic [KM_AW-1:0] idx, input logic [CODE_W-1:0] code);
        t_in_item item;
        item.opcode    = OP_MAP_WRITE;
        item.column    = COL_W'($urandom);
        item.row_raw   = MAX_ROWS'($urandom);
        item.map_index = idx;
        item.map_code  = code;
        push_item(item);
    endtask

    task automatic scan(input logic [COL_W-1:0] col, input logic [MAX_ROWS-1:0] raw);
        t_in_item item;
        item.opcode    = OP_SAMPLE;
        item.column    = col;
        item.row_raw   = raw;
        item.map_index = KM_AW'($urandom);
        item.map_code  = CODE_W'($urandom);
        push_item(item);
    endtask

    // one register access: setup cycle, then access cycle
    task automatic reg_access(input logic wr, input logic idx, input logic [CNT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hold the sender until every expected keycode is out, then wait a little longer
    task automatic drain(input int quiet);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (quiet) @(posedge i_clk);
    endtask

    initial begin
        int unsigned ecols;
        int unsigned col;
        logic [MAX_ROWS-1:0] raw;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default 8x8 layout, row shift 3
        map_write(6'd0, 16'h0001);
        map_write(6'd8, 16'h8000);
        map_write(6'd56, 16'hffff);
        map_write(6'd63, 16'h5a5a);
        map_write(6'd7, 16'h0007);
        map_write(6'd16, 16'h0000);
        scan(3'd0, 8'h00);          // all rows at once, three mapped
        scan(3'd0, 8'h00);          // held keys give nothing
        scan(3'd0, 8'hff);          // release only
        scan(3'd7, 8'h7f);          // top row, last keymap entry
        scan(3'd7, 8'hfe);          // row 0 pressed while row 7 released
        map_write(6'd8, 16'h0000);  // unmap an entry again
        scan(3'd0, 8'hfc);
        scan(3'd7, 8'h00);
        scan(3'd7, 8'hff);
        scan(3'd0, 8'hff);

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            drain(20);
            reg_access(1'b1, REG_NUM_ROWS, CNT_W'(rows_cfg[ph]));
            reg_access(1'b1, REG_NUM_COLS, CNT_W'(cols_cfg[ph]));
            reg_access(1'b0, REG_NUM_ROWS, '0);
            reg_access(1'b0, REG_NUM_COLS, '0);
            calm  <= (ph == 3);
            ecols = (cols_cfg[ph] > MAX_COLS) ? MAX_COLS : cols_cfg[ph];
            for (int k = 0; k < 26; k++) begin
                if (ph == 2 && k == 13) drain(0);
                if (k < 8 || $urandom_range(0, 9) == 0) begin
                    map_write(KM_AW'($urandom),
                              ($urandom_range(0, 6) == 0) ? 16'h0000 : CODE_W'($urandom));
                end else begin
                    col = (ecols > 0 && $urandom_range(0, 4) != 0) ?
                          $urandom_range(0, ecols - 1) : $urandom_range(0, 7);
                    case ($urandom_range(0, 9))
                        0, 1:    raw = 8'hff;
                        2:       raw = 8'h00;
                        default: raw = MAX_ROWS'($urandom);
                    endcase
                    scan(COL_W'(col), raw);
                end
            end
        end

        drain(30);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("sent %0d items (%0d row samples, %0d keymap writes) over %0d layouts",
                 items_sent, samples_sent, items_sent - samples_sent, PHASES + 1);
        $display("%0d keycodes compared, %0d mismatches", key_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("[matrix_keypad_press_detector_core] OK");
        end else begin
            $display("[matrix_keypad_press_detector_core] ERROR");
        end
        $finish;
    end

endmodule
